FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the delay line modules. Every module that uses
// them has a clock named i_clk and an active-low synchronous reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ACDL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent now, consequent at the next edge.
`define ACDL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/acdl_pkg.sv
// ----------------------------------------------------------------------------
// acdl_pkg
// Types and constants of the adjustable complex delay line.
// ----------------------------------------------------------------------------
package acdl_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS     = 16;
    localparam int BUF_LEN_BITS    = 11;
    localparam int INIT_DELAY_BITS = 10;
    localparam int DELAY_OUT_BITS  = 10;
    localparam int CFG_DATA_BITS   = 11;

    localparam logic [BUF_LEN_BITS-1:0]    BUF_LEN_RESET    = 11'd1024;
    localparam logic [INIT_DELAY_BITS-1:0] INIT_DELAY_RESET = 10'd0;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_BUFFER_LENGTH = 1'b0,
        CFG_INITIAL_DELAY = 1'b1
    } t_cfg_index;

    // Operation codes
    typedef enum logic [1:0] {
        OP_SAMPLE    = 2'd0,
        OP_INC_DELAY = 2'd1,
        OP_DEC_DELAY = 2'd2,
        OP_RESTART   = 2'd3
    } t_op;

    typedef struct packed {
        t_op                            operation;
        logic signed [SAMPLE_BITS-1:0]  real_in;
        logic signed [SAMPLE_BITS-1:0]  imag_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0]  real_out;
        logic signed [SAMPLE_BITS-1:0]  imag_out;
        logic                           status;
        logic [DELAY_OUT_BITS-1:0]      current_delay;
    } t_out_item;

    // Per-item control passed from the index unit to the result stage
    typedef struct packed {
        logic sample;   // item reads the store
        logic fwd;      // read hits the entry written by the same item
        logic status;   // 1: request refused
    } t_step_info;

endpackage

FILE: rtl/acdl_store.sv
// ----------------------------------------------------------------------------
// acdl_store
// Simple dual-port sample store: one write port, one read port with
// registered read data. Read data holds between reads.
// ----------------------------------------------------------------------------
module acdl_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:DEPTH-1];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/acdl_ctrl.sv
// ----------------------------------------------------------------------------
// acdl_ctrl
// Index unit: write/read indices and delay count, per-item decode, store
// port control and the clearing sweep run after reset and on restart.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acdl_ctrl
    import acdl_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    parameter int AW          = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  t_in_item                    i_item,
    input  logic [BUF_LEN_BITS-1:0]     i_buffer_length,
    input  logic [INIT_DELAY_BITS-1:0]  i_initial_delay,
    output logic                        o_ready,
    output t_step_info                  o_info,
    output logic [DELAY_OUT_BITS-1:0]   o_delay,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic [2*SAMPLE_BITS-1:0]    o_wdata,
    output logic                        o_re,
    output logic [AW-1:0]               o_raddr
);

    // Compare width covers both the register and the store length
    localparam int CW = ((AW + 1) > BUF_LEN_BITS) ? (AW + 1) : BUF_LEN_BITS;

    typedef enum logic [0:0] {
        ST_CLEAR,
        ST_RUN
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] r_clr_last;
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [AW-1:0] r_dly,    n_dly;

    logic [CW-1:0]      w_bl_ext;
    logic [CW-1:0]      w_len_c;
    logic [CW-1:0]      w_init_ext;
    logic [AW:0]        w_len;
    logic [AW:0]        w_len_m1;
    logic               w_status;
    logic               w_restart_go;
    logic               w_clearing;
    logic [AW+DELAY_OUT_BITS-1:0] w_dly_ext;

    // Index step with wrap at the active length
    function automatic logic [AW-1:0] f_advance(input logic [AW-1:0] idx,
                                                input logic [AW:0]   len);
        logic [AW:0] nx;
        nx = {1'b0, idx} + {{AW{1'b0}}, 1'b1};
        return (nx >= len) ? '0 : nx[AW-1:0];
    endfunction

    // Active length: zero acts as one, clipped to the store depth
    always_comb begin
        w_bl_ext   = CW'(i_buffer_length);
        w_init_ext = CW'(i_initial_delay);
        if (w_bl_ext == '0) begin
            w_len_c = CW'(1);
        end else if (w_bl_ext > CW'(STORE_DEPTH)) begin
            w_len_c = CW'(STORE_DEPTH);
        end else begin
            w_len_c = w_bl_ext;
        end
    end

    assign w_len    = w_len_c[AW:0];
    assign w_len_m1 = w_len - {{AW{1'b0}}, 1'b1};

    // Per-item index and delay update
    always_comb begin
        n_wr_idx     = r_wr_idx;
        n_rd_idx     = r_rd_idx;
        n_dly        = r_dly;
        w_status     = 1'b0;
        w_restart_go = 1'b0;
        if (i_fire) begin
            case (i_item.operation)
                OP_SAMPLE: begin
                    n_wr_idx = f_advance(r_wr_idx, w_len);
                    n_rd_idx = f_advance(r_rd_idx, w_len);
                end
                OP_INC_DELAY: begin
                    if ({1'b0, r_dly} < w_len_m1) begin
                        n_rd_idx = (r_rd_idx == '0) ? w_len_m1[AW-1:0]
                                                    : r_rd_idx - 1'b1;
                        n_dly    = r_dly + 1'b1;
                    end else begin
                        w_status = 1'b1;
                    end
                end
                OP_DEC_DELAY: begin
                    if (r_dly != '0) begin
                        n_rd_idx = f_advance(r_rd_idx, w_len);
                        n_dly    = r_dly - 1'b1;
                    end else begin
                        w_status = 1'b1;
                    end
                end
                OP_RESTART: begin
                    if (w_init_ext >= w_len_c) begin
                        w_status = 1'b1;
                    end else begin
                        w_restart_go = 1'b1;
                        n_wr_idx     = w_init_ext[AW-1:0];
                        n_rd_idx     = '0;
                        n_dly        = w_init_ext[AW-1:0];
                    end
                end
                default: begin
                    w_status = 1'b0;
                end
            endcase
        end
    end

    // Result side info
    assign w_dly_ext = {{DELAY_OUT_BITS{1'b0}}, n_dly};
    assign o_delay   = w_dly_ext[DELAY_OUT_BITS-1:0];
    assign o_info    = '{sample: (i_item.operation == OP_SAMPLE),
                         fwd:    (r_wr_idx == r_rd_idx),
                         status: w_status};

    // Store ports: sweep writes zeros, samples write the input pair
    assign w_clearing = (r_state == ST_CLEAR);
    assign o_ready    = !w_clearing;
    assign o_we       = w_clearing || (i_fire && i_item.operation == OP_SAMPLE);
    assign o_waddr    = w_clearing ? r_clr_addr : r_wr_idx;
    assign o_wdata    = w_clearing ? '0 : {i_item.real_in, i_item.imag_in};
    assign o_re       = i_fire && (i_item.operation == OP_SAMPLE);
    assign o_raddr    = r_rd_idx;

    // State, indices and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_clr_last <= AW'(STORE_DEPTH - 1);
            r_wr_idx   <= '0;
            r_rd_idx   <= '0;
            r_dly      <= '0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_dly    <= n_dly;
            case (r_state)
                ST_CLEAR: begin
                    if (r_clr_addr == r_clr_last) begin
                        r_state <= ST_RUN;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                ST_RUN: begin
                    if (w_restart_go) begin
                        r_state    <= ST_CLEAR;
                        r_clr_addr <= '0;
                        r_clr_last <= w_len_m1[AW-1:0];
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end
    end

    `ACDL_ASSERT(a_no_item_in_sweep, i_fire |-> (r_state == ST_RUN), "item accepted during clear")
    `ACDL_ASSERT_NEXT(a_sweep_steps, (r_state == ST_CLEAR && r_clr_addr != r_clr_last), (r_clr_addr == $past(r_clr_addr) + 1'b1), "clear sweep skipped an entry")
    `ACDL_ASSERT_NEXT(a_restart_clears, (i_fire && i_item.operation == OP_RESTART && !w_status), (r_state == ST_CLEAR && r_clr_addr == '0), "restart did not start clear")

endmodule

FILE: rtl/adjustable_complex_delay_line_core.sv
// ----------------------------------------------------------------------------
// adjustable_complex_delay_line_core
// Complex delay line over a circular sample store with adjustable delay.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one item per
//   operation: sample, increase delay, decrease delay or restart. Each item
//   gives exactly one result item on the output channel (o_out_valid /
//   i_out_stall / o_out_item), in order.
//   Each result passes through the read stage and then the output register.
//   Throughput: one item per cycle for sample and delay steps while the
//   output is not stalled; a sample writes and reads the store in the same
//   cycle. After a restart, a sweep over every entry in use (buffer_length
//   held to 1..STORE_DEPTH) zeroes the store and no item is taken meanwhile.
//   Reset: indices, delay and initial_delay go to zero, buffer_length to 1024;
//   a sweep over all STORE_DEPTH entries zeroes the store before the first item.
//   Receiver stall: the output register holds; one more result waits in the
//   read stage, after which o_in_stall rises.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adjustable_complex_delay_line_core
    import acdl_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_in_item                  i_in_item,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_out_item                 o_out_item,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int DW = 2 * SAMPLE_BITS;

    logic [BUF_LEN_BITS-1:0]    r_buffer_length;
    logic [INIT_DELAY_BITS-1:0] r_initial_delay;

    logic                       w_ready;
    logic                       w_in_fire;
    logic                       w_out_free;
    logic                       w_s1_move;
    t_step_info                 w_info;
    logic [DELAY_OUT_BITS-1:0]  w_delay;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [DW-1:0]              w_wdata;
    logic                       w_re;
    logic [AW-1:0]              w_raddr;
    logic [DW-1:0]              w_rdata;
    logic [DW-1:0]              w_pair;

    logic                       r_s1_valid;
    t_step_info                 r_s1_info;
    logic [DW-1:0]              r_s1_fwd;
    logic [DELAY_OUT_BITS-1:0]  r_s1_delay;
    logic                       r_out_valid;
    t_out_item                  r_out_item;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_length <= BUF_LEN_RESET;
            r_initial_delay <= INIT_DELAY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BUFFER_LENGTH: r_buffer_length <= i_cfg_wdata[BUF_LEN_BITS-1:0];
                CFG_INITIAL_DELAY: r_initial_delay <= i_cfg_wdata[INIT_DELAY_BITS-1:0];
                default:           r_buffer_length <= r_buffer_length;
            endcase
        end
    end

    // Handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign o_in_stall = !(w_ready && (!r_s1_valid || w_out_free));
    assign w_in_fire  = i_in_valid && !o_in_stall;

    acdl_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_in_fire),
        .i_item          (i_in_item),
        .i_buffer_length (r_buffer_length),
        .i_initial_delay (r_initial_delay),
        .o_ready         (w_ready),
        .o_info          (w_info),
        .o_delay         (w_delay),
        .o_we            (w_we),
        .o_waddr         (w_waddr),
        .o_wdata         (w_wdata),
        .o_re            (w_re),
        .o_raddr         (w_raddr)
    );

    acdl_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Read stage: waits for store data; holds while the output is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_info  <= w_info;
            r_s1_fwd   <= {i_in_item.real_in, i_in_item.imag_in};
            r_s1_delay <= w_delay;
        end
    end

    // Same entry written and read: take the incoming pair
    assign w_pair = r_s1_info.fwd ? r_s1_fwd : w_rdata;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_item.real_out      <= r_s1_info.sample ? w_pair[DW-1:SAMPLE_BITS] : '0;
            r_out_item.imag_out      <= r_s1_info.sample ? w_pair[SAMPLE_BITS-1:0] : '0;
            r_out_item.status        <= r_s1_info.status;
            r_out_item.current_delay <= r_s1_delay;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `ACDL_ASSERT(a_s1_no_overrun, (r_s1_valid && !w_s1_move) |-> !w_in_fire, "read stage overrun")
    `ACDL_ASSERT_NEXT(a_s1_to_out, w_s1_move, r_out_valid, "result lost between stages")
    `ACDL_ASSERT(a_fwd_flag, w_re |-> ((w_waddr == w_raddr) == w_info.fwd), "bad forward flag")

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the adjustable complex delay line. Items are driven
// through the valid/stall input channel under several idle patterns. A
// behavioral copy of the circular store predicts every result. The output
// channel is compared field by field with that prediction, in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import acdl_pkg::*;

    localparam int DEPTH         = 1024;
    localparam int SETTLE_CYCLES = DEPTH + 64;  // covers a full clearing sweep
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_SHOWN     = 10;

    // DUT ports
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    t_in_item                 i_in_item   = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    t_out_item                o_out_item;
    logic                     i_cfg_we    = 1'b0;
    logic [0:0]               i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata = '0;

    // Behavioral copy of the delay line
    logic [SAMPLE_BITS-1:0]     re_mem [DEPTH];
    logic [SAMPLE_BITS-1:0]     im_mem [DEPTH];
    int unsigned                wr_ptr;
    int unsigned                rd_ptr;
    int unsigned                delay_now;
    logic [BUF_LEN_BITS-1:0]    len_reg;
    logic [INIT_DELAY_BITS-1:0] init_reg;

    // Predicted outputs still to come, oldest first
    t_out_item due_outputs[$];

    int fail_count    = 0;
    int checked_count = 0;
    int n_refused     = 0;
    int n_cfg_writes  = 0;
    int n_op[4]       = '{default: 0};

    // Idle control
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_tickets   = 0;  // bumped by a test to request a long hold-off
    int hold_served    = 0;
    int hold_left      = 0;

    adjustable_complex_delay_line_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Length actually in use: zero acts as one, oversize clamps to the store
    function automatic int unsigned active_length();
        if (len_reg == '0) return 1;
        if (len_reg > DEPTH) return DEPTH;
        return 32'(len_reg);
    endfunction

    function automatic int unsigned wrap_next(int unsigned idx, int unsigned len);
        return (idx + 1 >= len) ? 0 : idx + 1;
    endfunction

    // Apply one item to the copy of the store and return its result
    function automatic t_out_item delay_line_step(t_in_item it);
        t_out_item   res;
        int unsigned len;
        res = '0;
        len = active_length();
        case (it.operation)
            OP_SAMPLE: begin
                // write first, so zero delay hands back the input
                re_mem[wr_ptr] = it.real_in;
                im_mem[wr_ptr] = it.imag_in;
                wr_ptr = wrap_next(wr_ptr, len);
                res.real_out = re_mem[rd_ptr];
                res.imag_out = im_mem[rd_ptr];
                rd_ptr = wrap_next(rd_ptr, len);
            end
            OP_INC_DELAY: begin
                if (delay_now < len - 1) begin
                    rd_ptr = (rd_ptr == 0) ? len - 1 : rd_ptr - 1;
                    delay_now++;
                end else begin
                    res.status = 1'b1;
                end
            end
            OP_DEC_DELAY: begin
                if (delay_now > 0) begin
                    rd_ptr = wrap_next(rd_ptr, len);
                    delay_now--;
                end else begin
                    res.status = 1'b1;
                end
            end
            default: begin
                // restart: refused when the preset does not fit the length
                if (init_reg >= len) begin
                    res.status = 1'b1;
                end else begin
                    for (int k = 0; k < len; k++) begin
                        re_mem[k] = '0;
                        im_mem[k] = '0;
                    end
                    wr_ptr    = 32'(init_reg);
                    rd_ptr    = 0;
                    delay_now = 32'(init_reg);
                end
            end
        endcase
        res.current_delay = delay_now[DELAY_OUT_BITS-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one item; entered and left at a falling edge. Valid stays high
    // so back-to-back items need no second assignment in one step.
    task automatic send_item(input t_in_item it);
        t_out_item want;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        want = delay_line_step(it);
        due_outputs.push_back(want);
        n_op[int'(it.operation)]++;
        if (want.status) n_refused++;
        @(negedge i_clk);
    endtask

    // Stop offering, wait for every result, then let any clearing sweep end
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (due_outputs.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write both registers while the block is idle
    task automatic configure(input logic [CFG_DATA_BITS-1:0] len,
                             input logic [CFG_DATA_BITS-1:0] init);
        quiesce();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BUFFER_LENGTH;
        i_cfg_wdata <= len;
        @(negedge i_clk);
        i_cfg_index <= CFG_INITIAL_DELAY;
        i_cfg_wdata <= init;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        len_reg  = len[BUF_LEN_BITS-1:0];
        init_reg = init[INIT_DELAY_BITS-1:0];
        n_cfg_writes += 2;
    endtask

    function automatic t_in_item mk(t_op op, int re, int im);
        t_in_item it;
        it.operation = op;
        it.real_in   = SAMPLE_BITS'(re);
        it.imag_in   = SAMPLE_BITS'(im);
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        pick = $urandom_range(99);
        it.real_in = SAMPLE_BITS'($urandom);
        it.imag_in = SAMPLE_BITS'($urandom);
        if (pick < 60)      it.operation = OP_SAMPLE;
        else if (pick < 76) it.operation = OP_INC_DELAY;
        else if (pick < 93) it.operation = OP_DEC_DELAY;
        else                it.operation = OP_RESTART;
        return it;
    endfunction

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_served != hold_tickets) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_served <= hold_tickets;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (due_outputs.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("%0t: result with none pending: %p", $realtime, o_out_item);
            end else begin
                want = due_outputs.pop_front();
                checked_count++;
                if (o_out_item.real_out !== want.real_out ||
                    o_out_item.imag_out !== want.imag_out ||
                    o_out_item.status !== want.status ||
                    o_out_item.current_delay !== want.current_delay) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN) begin
                        $write("%0t: result %0d expected re=%0d im=%0d st=%0b dly=%0d,",
                               $realtime, checked_count,
                               want.real_out, want.imag_out, want.status,
                               want.current_delay);
                        $display(" got re=%0d im=%0d st=%0b dly=%0d",
                                 o_out_item.real_out, o_out_item.imag_out,
                                 o_out_item.status, o_out_item.current_delay);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Zero delay after reset: each sample comes straight back
    task automatic test_zero_delay_extremes();
        send_item(mk(OP_SAMPLE, 32767, -32768));
        send_item(mk(OP_SAMPLE, -32768, 32767));
        send_item(mk(OP_SAMPLE, 0, -1));
        send_item(mk(OP_SAMPLE, -1, 0));
    endtask

    // Step the delay up and down, including a refused decrease at zero
    task automatic test_delay_steps();
        send_item(mk(OP_INC_DELAY, 0, 0));
        send_item(mk(OP_SAMPLE, 1, 2));
        send_item(mk(OP_SAMPLE, 3, 4));
        send_item(mk(OP_DEC_DELAY, 0, 0));
        send_item(mk(OP_DEC_DELAY, 0, 0));
    endtask

    // Restart presets, refused increase at the top, restart refused
    task automatic test_restart_rules();
        configure(3, 2);
        send_item(mk(OP_RESTART, 0, 0));
        send_item(mk(OP_SAMPLE, 5, 6));
        send_item(mk(OP_SAMPLE, 7, 8));
        send_item(mk(OP_SAMPLE, 9, 10));
        send_item(mk(OP_INC_DELAY, 0, 0));
        send_item(mk(OP_DEC_DELAY, 0, 0));
        configure(3, 3);
        send_item(mk(OP_RESTART, 0, 0));
    endtask

    // Length of zero, oversize length, and shrinking the length mid-stream
    task automatic test_length_limits();
        configure(0, 0);
        send_item(mk(OP_RESTART, 0, 0));
        send_item(mk(OP_SAMPLE, 11, -11));
        send_item(mk(OP_INC_DELAY, 0, 0));
        send_item(mk(OP_DEC_DELAY, 0, 0));
        configure(2047, 1023);
        send_item(mk(OP_RESTART, 0, 0));
        send_item(mk(OP_INC_DELAY, 0, 0));
        // write index sits far above the new length
        configure(4, 1023);
        send_item(mk(OP_SAMPLE, 12, 13));
        send_item(mk(OP_DEC_DELAY, 0, 0));
        send_item(mk(OP_INC_DELAY, 0, 0));
    endtask

    // Random traffic in segments, each under a fresh register setting
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int count);
        int unsigned len;
        int unsigned top;
        send_gap_pct   = send_pct;
        recv_stall_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(9))
                    0:       len = 0;
                    1:       len = 1;
                    2:       len = 2;
                    3:       len = $urandom_range(2047, 1024);
                    4:       len = DEPTH;
                    default: len = $urandom_range(48, 3);
                endcase
                top = (len == 0) ? 0 : ((len > DEPTH) ? DEPTH - 1 : len - 1);
                if ($urandom_range(4) == 0)
                    configure(CFG_DATA_BITS'(len), CFG_DATA_BITS'($urandom_range(1023)));
                else
                    configure(CFG_DATA_BITS'(len), CFG_DATA_BITS'($urandom_range(top)));
            end
            send_item(random_item());
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        configure(16, 5);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        send_item(mk(OP_RESTART, 0, 0));
        hold_tickets++;
        for (int n = 0; n < 60; n++) send_item(random_item());
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        foreach (re_mem[k]) begin
            re_mem[k] = '0;
            im_mem[k] = '0;
        end
        wr_ptr    = 0;
        rd_ptr    = 0;
        delay_now = 0;
        len_reg   = BUF_LEN_RESET;
        init_reg  = INIT_DELAY_RESET;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct   = 30;
        recv_stall_pct = 62;
        test_zero_delay_extremes();
        test_delay_steps();
        test_restart_rules();
        test_length_limits();

        test_random_traffic(30, 62, 150);
        test_random_traffic(62, 30, 150);
        test_random_traffic(0, 0, 110);
        test_backpressure();

        quiesce();
        if (due_outputs.size() != 0) fail_count += due_outputs.size();

        $display("Ran %0d samples, %0d increases, %0d decreases, %0d restarts",
                 n_op[0], n_op[1], n_op[2], n_op[3]);
        $display("%0d results checked, %0d refused requests, %0d register writes",
                 checked_count, n_refused, n_cfg_writes);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
